[hw/rtl/joce_pkg.sv]
// joce_pkg: shared types, codes and constants of the octic conjugate julia engine
// used by joce_ctrl, joce_dp and julia_octic_conjugate_escape; no dependencies
`timescale 1ns / 1ps

package joce_pkg;

	// frame geometry default
	localparam int FRAME_SIZE_DEF = 1024;

	// field widths
	localparam int PIX_W   = 10;
	localparam int Q_W     = 32;
	localparam int SCALE_W = 31;
	localparam int CNT_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int LVL_W   = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CONST_REAL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONST_IMAG  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SCALE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT  = 3'd5;

	// register reset values
	localparam logic [SCALE_W-1:0] SCALE_RST = 31'd1048576;
	localparam logic [CNT_W-1:0]   LIMIT_RST = 16'd50;

	// last squaring level (z^8)
	localparam logic [LVL_W-1:0] LVL_LAST = 2'd2;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SX,
		ST_SY,
		ST_SZ,
		ST_A,
		ST_B,
		ST_C,
		ST_D,
		ST_E,
		ST_FIN
	} state_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MULX,
		OP_MULY,
		OP_ZI,
		OP_A,
		OP_B,
		OP_C,
		OP_D,
		OP_E
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [LVL_W-1:0] level;
		logic             load_res;
	} cmd_t;

	typedef struct packed {
		logic escape;
		logic sat_now;
		logic cnt_done;
	} status_t;

endpackage

[hw/rtl/joce_ctrl.sv]
// joce_ctrl: sequencer of the escape-time loop, drives joce_dp by command struct
// depends on joce_pkg
`timescale 1ns / 1ps

module joce_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  joce_pkg::status_t  sts,
	output joce_pkg::cmd_t     cmd
);

	joce_pkg::state_t              state_q, state_d;
	logic [joce_pkg::LVL_W-1:0]    level_q, level_d;
	logic                          out_valid_q, out_valid_d;

	// state, level and result flag registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= joce_pkg::ST_IDLE;
			level_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			level_q     <= level_d;
			out_valid_q <= out_valid_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		level_d      = level_q;
		out_valid_d  = out_valid_q;
		cmd.op       = joce_pkg::OP_NONE;
		cmd.level    = level_q;
		cmd.load_res = 1'b0;
		if (out_valid_q && out_ready) out_valid_d = 1'b0;
		case (state_q)
			joce_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = joce_pkg::OP_LOAD;
					state_d = joce_pkg::ST_SX;
				end
			end
			joce_pkg::ST_SX: begin
				cmd.op  = joce_pkg::OP_MULX;
				state_d = joce_pkg::ST_SY;
			end
			joce_pkg::ST_SY: begin
				cmd.op  = joce_pkg::OP_MULY;
				state_d = joce_pkg::ST_SZ;
			end
			joce_pkg::ST_SZ: begin
				cmd.op  = joce_pkg::OP_ZI;
				level_d = '0;
				state_d = joce_pkg::ST_A;
			end
			joce_pkg::ST_A: begin
				if (level_q == '0 && sts.cnt_done) begin
					state_d = joce_pkg::ST_FIN;
				end else begin
					cmd.op  = joce_pkg::OP_A;
					state_d = joce_pkg::ST_B;
				end
			end
			joce_pkg::ST_B: begin
				cmd.op  = joce_pkg::OP_B;
				state_d = joce_pkg::ST_C;
			end
			joce_pkg::ST_C: begin
				cmd.op = joce_pkg::OP_C;
				if (level_q == '0 && sts.escape) state_d = joce_pkg::ST_FIN;
				else state_d = joce_pkg::ST_D;
			end
			joce_pkg::ST_D: begin
				cmd.op = joce_pkg::OP_D;
				if (level_q == joce_pkg::LVL_LAST) begin
					state_d = joce_pkg::ST_E;
				end else begin
					level_d = level_q + 1'b1;
					state_d = joce_pkg::ST_A;
				end
			end
			joce_pkg::ST_E: begin
				cmd.op  = joce_pkg::OP_E;
				level_d = '0;
				if (sts.sat_now) state_d = joce_pkg::ST_FIN;
				else state_d = joce_pkg::ST_A;
			end
			joce_pkg::ST_FIN: begin
				// hand the count over once the output slot is free
				if (!out_valid_q || out_ready) begin
					cmd.load_res = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = joce_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = joce_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_ready  = (state_q == joce_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	// checks
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q != 2'd3) else $error("squaring level out of range");
	a_res_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_res |-> (!out_valid_q || out_ready))
		else $error("result overwritten before taken");
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == joce_pkg::ST_SX))
		else $error("accepted item did not start");

endmodule

[hw/rtl/joce_dp.sv]
// joce_dp: configuration registers, shared multiplier and iteration registers
// depends on joce_pkg; driven by joce_ctrl commands
`timescale 1ns / 1ps

module joce_dp #(
	parameter int FRAME_SIZE = joce_pkg::FRAME_SIZE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [joce_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data,
	input  logic [joce_pkg::PIX_W-1:0]        pixel_x,
	input  logic [joce_pkg::PIX_W-1:0]        pixel_y,
	input  joce_pkg::cmd_t                    cmd,
	output joce_pkg::status_t                 sts,
	output logic [joce_pkg::CNT_W-1:0]        iter_count
);

	localparam logic signed [33:0] CENTER = 34'((FRAME_SIZE / 2) * 256);
	localparam logic [64:0] ESC_SQ = 65'd1 << 58;

	// saturate a 34-bit value to q4.28, flag in the top bit
	function automatic logic [32:0] sat34(input logic signed [33:0] v);
		if (v[33:31] == 3'b000 || v[33:31] == 3'b111) return {1'b0, v[31:0]};
		else if (v[33]) return {1'b1, 32'h8000_0000};
		else return {1'b1, 32'h7fff_ffff};
	endfunction

	// product back to q4.28, floor shift then saturate
	function automatic logic [32:0] qmul(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = p >>> 28;
		if ((&t[63:31]) || !(|t[63:31])) return {1'b0, t[31:0]};
		else if (t[63]) return {1'b1, 32'h8000_0000};
		else return {1'b1, 32'h7fff_ffff};
	endfunction

	// start point from magnitude times scale, truncated toward zero
	function automatic logic [31:0] spoint(input logic [62:0] p, input logic neg);
		logic [54:0] sh;
		sh = p[62:8];
		if (neg) begin
			if (sh > 55'h8000_0000) return 32'h8000_0000;
			else return 32'(-sh);
		end else begin
			if (sh > 55'h7fff_ffff) return 32'h7fff_ffff;
			else return sh[31:0];
		end
	endfunction

	logic signed [31:0]             cr_q, ci_q, ox_q, oy_q;
	logic [joce_pkg::SCALE_W-1:0]   scale_q;
	logic [joce_pkg::CNT_W-1:0]     lim_q;
	logic [31:0]                    magx_q, magy_q;
	logic                           negx_q, negy_q;
	logic signed [65:0]             prod_q;
	logic signed [31:0]             zr_q, zi_q, wr_q, wi_q, r4_q, i4_q, aa_q, bb_q;
	logic [63:0]                    a2_q;
	logic                           sat_q;
	logic [joce_pkg::CNT_W-1:0]     count_q, res_q;

	logic signed [33:0] px, py;
	logic signed [32:0] opa, opb;
	logic [32:0]        q_r, sub_r, dbl_r, sr_r, si_r, ng_r;
	logic               lvl0;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_q    <= '0;
			ci_q    <= '0;
			ox_q    <= '0;
			oy_q    <= '0;
			scale_q <= joce_pkg::SCALE_RST;
			lim_q   <= joce_pkg::LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				joce_pkg::REG_CONST_REAL:  cr_q    <= cfg_data;
				joce_pkg::REG_CONST_IMAG:  ci_q    <= cfg_data;
				joce_pkg::REG_OFFSET_X:    ox_q    <= cfg_data;
				joce_pkg::REG_OFFSET_Y:    oy_q    <= cfg_data;
				joce_pkg::REG_PIXEL_SCALE: scale_q <= cfg_data[joce_pkg::SCALE_W-1:0];
				joce_pkg::REG_ITER_LIMIT:  lim_q   <= cfg_data[joce_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// pixel position in q26.8 relative to the frame centre
	assign px = $signed({16'd0, pixel_x, 8'd0}) + 34'(ox_q) - CENTER;
	assign py = $signed({16'd0, pixel_y, 8'd0}) + 34'(oy_q) - CENTER;

	assign lvl0 = (cmd.level == '0);

	// shared multiplier operand select
	always_comb begin
		case (cmd.op)
			joce_pkg::OP_MULX: begin
				opa = {1'b0, magx_q};
				opb = {2'b0, scale_q};
			end
			joce_pkg::OP_MULY: begin
				opa = {1'b0, magy_q};
				opb = {2'b0, scale_q};
			end
			joce_pkg::OP_B: begin
				opa = lvl0 ? 33'(zi_q) : 33'(wi_q);
				opb = opa;
			end
			joce_pkg::OP_C: begin
				opa = lvl0 ? 33'(zr_q) : 33'(wr_q);
				opb = lvl0 ? 33'(zi_q) : 33'(wi_q);
			end
			default: begin
				opa = lvl0 ? 33'(zr_q) : 33'(wr_q);
				opb = opa;
			end
		endcase
	end

	// rescale and combine
	assign q_r   = qmul(prod_q[63:0]);
	assign sub_r = sat34(34'(aa_q) - 34'(bb_q));
	assign dbl_r = sat34({q_r[31], q_r[31:0], 1'b0});
	assign sr_r  = sat34(34'(wr_q) + 34'(r4_q) + 34'(cr_q));
	assign si_r  = sat34(34'(wi_q) + 34'(i4_q) + 34'(ci_q));
	assign ng_r  = sat34(-34'($signed(si_r[31:0])));

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= opa * opb;
		case (cmd.op)
			joce_pkg::OP_LOAD: begin
				magx_q  <= px[33] ? 32'(-px) : px[31:0];
				magy_q  <= py[33] ? 32'(-py) : py[31:0];
				negx_q  <= px[33];
				negy_q  <= py[33];
				count_q <= '0;
			end
			joce_pkg::OP_MULY: zr_q <= spoint(prod_q[62:0], negx_q);
			joce_pkg::OP_ZI:   zi_q <= spoint(prod_q[62:0], negy_q);
			joce_pkg::OP_A: begin
				if (lvl0) sat_q <= 1'b0;
			end
			joce_pkg::OP_B: begin
				aa_q <= q_r[31:0];
				if (lvl0) a2_q <= prod_q[63:0];
				else if (q_r[32]) sat_q <= 1'b1;
				if (lvl0 && q_r[32]) sat_q <= 1'b1;
			end
			joce_pkg::OP_C: begin
				bb_q <= q_r[31:0];
				if (q_r[32]) sat_q <= 1'b1;
			end
			joce_pkg::OP_D: begin
				wr_q <= sub_r[31:0];
				wi_q <= dbl_r[31:0];
				if (cmd.level == 2'd1) begin
					r4_q <= sub_r[31:0];
					i4_q <= dbl_r[31:0];
				end
				if (q_r[32] || sub_r[32] || dbl_r[32]) sat_q <= 1'b1;
			end
			joce_pkg::OP_E: begin
				zr_q    <= sr_r[31:0];
				zi_q    <= ng_r[31:0];
				count_q <= count_q + 1'b1;
			end
			default: ;
		endcase
		if (cmd.load_res) res_q <= count_q;
	end

	// status to the controller
	assign sts.escape   = ({1'b0, a2_q} + {1'b0, prod_q[63:0]}) >= ESC_SQ;
	assign sts.sat_now  = sat_q | sr_r[32] | si_r[32] | ng_r[32];
	assign sts.cnt_done = (count_q >= lim_q);

	assign iter_count = res_q;

endmodule

[hw/rtl/julia_octic_conjugate_escape.sv]
// From acceptance to result valid: the start point is formed, then each iteration
// runs three complex squarings of 3 multiplies and a combine on one shared 33x33
// multiplier, plus an update step; the limit, the escape test or a saturated
// iteration ends the pixel. One item in flight; an untaken result holds the next
// count. Reset: arst_n clears control state and loads register defaults (scale
// 1048576, iteration limit 50, others 0).
`timescale 1ns / 1ps

module julia_octic_conjugate_escape #(
	parameter int FRAME_SIZE = joce_pkg::FRAME_SIZE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [joce_pkg::PIX_W-1:0]      pixel_x,
	input  logic [joce_pkg::PIX_W-1:0]      pixel_y,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [joce_pkg::CNT_W-1:0]      iter_count,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [joce_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data
);

	joce_pkg::cmd_t    cmd;
	joce_pkg::status_t sts;

	// register writes always taken
	assign cfg_ready = 1'b1;

	// sequencer
	joce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// arithmetic
	joce_dp #(
		.FRAME_SIZE (FRAME_SIZE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.cmd        (cmd),
		.sts        (sts),
		.iter_count (iter_count)
	);

endmodule

[verif/julia_octic_conjugate_escape_tb.sv]
// julia_octic_conjugate_escape_tb: self-checking bench for the octic conjugate julia engine
// predicts each escape count in fixed point and checks it; depends on joce_pkg and the rtl top
`timescale 1ns / 1ps

// expected escape counts and the arithmetic that forms them
class escape_scoreboard;
	logic signed [31:0] c_re, c_im, off_x, off_y;
	logic [30:0] scale;
	logic [15:0] limit;
	logic [15:0] pending_counts[$];
	int errors;
	int checked;

	function new();
		c_re = 0;
		c_im = 0;
		off_x = 0;
		off_y = 0;
		scale = joce_pkg::SCALE_RST;
		limit = joce_pkg::LIMIT_RST;
		errors = 0;
		checked = 0;
	endfunction

	// register write as the block applies it
	function void set_reg(logic [2:0] idx, logic [31:0] data);
		case (idx)
			joce_pkg::REG_CONST_REAL: c_re = data;
			joce_pkg::REG_CONST_IMAG: c_im = data;
			joce_pkg::REG_OFFSET_X: off_x = data;
			joce_pkg::REG_OFFSET_Y: off_y = data;
			joce_pkg::REG_PIXEL_SCALE: scale = data[30:0];
			joce_pkg::REG_ITER_LIMIT: limit = data[15:0];
			default: ;
		endcase
	endfunction

	function int clamp32(longint v, inout bit sat);
		if (v > 64'sd2147483647) begin
			sat = 1;
			return 32'sh7fffffff;
		end
		if (v < -64'sd2147483648) begin
			sat = 1;
			return 32'sh80000000;
		end
		return int'(v);
	endfunction

	// q4.28 product, floor rounding
	function int fx_mul(int a, int b, inout bit sat);
		longint p;
		p = longint'(a) * longint'(b);
		return clamp32(p >>> 28, sat);
	endfunction

	// pixel to start point in q4.28
	function int start_coord(int unsigned pix, int off);
		longint p;
		longint unsigned mag, prod;
		bit junk;
		junk = 0;
		p = longint'(pix) * 256 + longint'(off) - longint'(1024 / 2) * 256;
		mag = (p < 0) ? longint'(-p) : longint'(p);
		prod = (mag * longint'(scale)) >> 8;
		if (p < 0) begin
			if (prod > 64'd2147483648)
				return 32'sh80000000;
			return clamp32(-longint'(prod), junk);
		end
		if (prod > 64'd2147483647)
			return 32'sh7fffffff;
		return int'(prod);
	endfunction

	function bit outside(int a, int b);
		longint unsigned s;
		s = longint'(a) * longint'(a) + longint'(b) * longint'(b);
		return s >= (64'd4 << 56);
	endfunction

	// escape time of one pixel
	function logic [15:0] escape_count(int unsigned px, int unsigned py);
		int zr, zi, r2, i2, r4, i4, r8, i8, nr, ni, t1, t2, t3;
		int unsigned n;
		bit sat;
		zr = start_coord(px, off_x);
		zi = start_coord(py, off_y);
		n = 0;
		while (n < limit && !outside(zr, zi)) begin
			sat = 0;
			t1 = fx_mul(zr, zr, sat); t2 = fx_mul(zi, zi, sat); t3 = fx_mul(zr, zi, sat);
			r2 = clamp32(longint'(t1) - t2, sat); i2 = clamp32(longint'(t3) * 2, sat);
			t1 = fx_mul(r2, r2, sat); t2 = fx_mul(i2, i2, sat); t3 = fx_mul(r2, i2, sat);
			r4 = clamp32(longint'(t1) - t2, sat); i4 = clamp32(longint'(t3) * 2, sat);
			t1 = fx_mul(r4, r4, sat); t2 = fx_mul(i4, i4, sat); t3 = fx_mul(r4, i4, sat);
			r8 = clamp32(longint'(t1) - t2, sat); i8 = clamp32(longint'(t3) * 2, sat);
			nr = clamp32(longint'(r8) + r4 + c_re, sat);
			ni = clamp32(longint'(i8) + i4 + c_im, sat);
			zr = nr;
			zi = clamp32(-longint'(ni), sat);
			n++;
			if (sat)
				break;
		end
		return n[15:0];
	endfunction

	function void note_pixel(logic [9:0] px, logic [9:0] py);
		pending_counts.push_back(escape_count(px, py));
	endfunction

	function void check_count(logic [15:0] got);
		logic [15:0] want;
		checked++;
		if (pending_counts.size() == 0) begin
			errors++;
			$display("%0t: unexpected count, expected none, actual %0d", $time, got);
			return;
		end
		want = pending_counts.pop_front();
		if (got !== want) begin
			errors++;
			$display("%0t: iter_count mismatch, expected %0d, actual %0d", $time, want, got);
		end
	endfunction
endclass

module julia_octic_conjugate_escape_tb;

	localparam logic [joce_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [joce_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int CYCLE_LIMIT = 3000000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [joce_pkg::PIX_W-1:0] pixel_x = 0;
	logic [joce_pkg::PIX_W-1:0] pixel_y = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [joce_pkg::CNT_W-1:0] iter_count;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [joce_pkg::CFG_IDX_W-1:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;

	escape_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycles = 0;
	int sent = 0;

	julia_octic_conjugate_escape uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.pixel_x(pixel_x), .pixel_y(pixel_y),
		.out_valid(out_valid), .out_ready(out_ready), .iter_count(iter_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// clock, 4 ns period
	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side: check accepted items, random stalls
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_count(iter_count);
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// one pixel item, with random idle cycles ahead of it
	task automatic send_pixel(logic [9:0] px, logic [9:0] py);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		pixel_x <= px;
		pixel_y <= py;
		do @(posedge clk); while (!in_ready);
		sb.note_pixel(px, py);
		sent++;
	endtask

	// wait for every expected count, then let the block settle
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending_counts.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// random settings, mostly in the interesting region
	task automatic random_setup();
		if ($urandom_range(3) == 0) begin
			write_reg(joce_pkg::REG_CONST_REAL, $urandom());
			write_reg(joce_pkg::REG_CONST_IMAG, $urandom());
		end else begin
			write_reg(joce_pkg::REG_CONST_REAL, $urandom_range(32'h4000_0000) - 32'h2000_0000);
			write_reg(joce_pkg::REG_CONST_IMAG, $urandom_range(32'h4000_0000) - 32'h2000_0000);
		end
		if ($urandom_range(3) == 0) begin
			write_reg(joce_pkg::REG_OFFSET_X, $urandom());
			write_reg(joce_pkg::REG_OFFSET_Y, $urandom());
		end else begin
			write_reg(joce_pkg::REG_OFFSET_X, $urandom_range(32'h4_0000) - 32'h2_0000);
			write_reg(joce_pkg::REG_OFFSET_Y, $urandom_range(32'h4_0000) - 32'h2_0000);
		end
		if ($urandom_range(4) == 0)
			write_reg(joce_pkg::REG_PIXEL_SCALE, $urandom());
		else
			write_reg(joce_pkg::REG_PIXEL_SCALE, $urandom_range(32'h80_0000, 32'h1_0000));
		write_reg(joce_pkg::REG_ITER_LIMIT,
			($urandom_range(7) == 0) ? 0 : $urandom_range(40));
	endtask

	initial begin
		int ph;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// corners and centre points under reset settings
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		send_pixel(512, 512);
		send_pixel(0, 1023);
		send_pixel(1023, 0);
		send_pixel(511, 513);
		drain();

		// largest limit with a constant that escapes at once
		write_reg(joce_pkg::REG_CONST_REAL, 32'h7fff_ffff);
		write_reg(joce_pkg::REG_ITER_LIMIT, 32'hffff_ffff);
		send_pixel(512, 512);
		send_pixel(500, 530);
		drain();

		// start point saturation, both signs, and product saturation
		write_reg(joce_pkg::REG_CONST_REAL, 32'h8000_0000);
		write_reg(joce_pkg::REG_CONST_IMAG, 32'h7fff_ffff);
		write_reg(joce_pkg::REG_PIXEL_SCALE, 32'h7fff_ffff);
		write_reg(joce_pkg::REG_OFFSET_X, 32'h7fff_ffff);
		write_reg(joce_pkg::REG_OFFSET_Y, 32'h8000_0000);
		write_reg(joce_pkg::REG_ITER_LIMIT, 20);
		send_pixel(1023, 0);
		send_pixel(0, 1023);
		send_pixel(512, 512);
		drain();

		// zero scale (top bit dropped), spare indexes ignored
		write_reg(joce_pkg::REG_PIXEL_SCALE, 32'h8000_0000);
		write_reg(joce_pkg::REG_CONST_REAL, 32'hf400_0000);
		write_reg(joce_pkg::REG_CONST_IMAG, 32'h0280_0000);
		write_reg(REG_SPARE_LO, 32'hffff_ffff);
		write_reg(REG_SPARE_HI, 32'h1234_5678);
		send_pixel(7, 900);
		send_pixel(1023, 1023);
		drain();

		// zero limit
		write_reg(joce_pkg::REG_ITER_LIMIT, 0);
		send_pixel(512, 512);
		send_pixel(3, 1000);
		drain();

		// random phases over the idling mixes
		for (ph = 0; ph < 13; ph++) begin
			case (ph % 5)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
				3: begin send_idle_pct = 19; recv_stall_pct = 19; end
				default: begin send_idle_pct = $urandom_range(30); recv_stall_pct = 0; end
			endcase
			random_setup();
			repeat (100) send_pixel($urandom_range(1023), $urandom_range(1023));
			drain();
		end

		$display("covered %0d pixels over 13 random setups plus corner and saturation cases",
			sent);
		$display("%0d counts checked, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending_counts.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
